[design/cga_pkg.sv]
// Shared types and constants for the channel group allocator.
// No dependencies; every other design file imports this package.
package cga_pkg;

  localparam int FUNC_W  = 2;
  localparam int COUNT_W = 6;
  localparam int SLOT_W  = 5;
  localparam int TAG_W   = 16;
  localparam int MASK_W  = 32;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SWEEP = 2'd3;

  // Step the datapath performs in the current cycle.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SCAN,
    OP_STAMP,
    OP_STOP_CHK,
    OP_QUERY_CHK,
    OP_CLEAR,
    OP_SWEEP
  } op_e;

  typedef struct packed {
    op_e  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic bad_count;
    logic found;
    logic last;
    logic stamp_last;
    logic trk_hit;
    logic run_go;
    logic out_free;
  } sts_t;

endpackage

[design/cga_if.sv]
// Request and response channel interfaces of the channel group allocator.
// Depends on cga_pkg for the field widths.
interface cga_req_if import cga_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [COUNT_W-1:0]  run_len;
  logic                is_tracker;
  logic [SLOT_W-1:0]   slot;
  logic [TAG_W-1:0]    tag;
  logic [MASK_W-1:0]   playing_mask;

  modport source (output valid, func, run_len, is_tracker, slot, tag, playing_mask,
                  input ready);
  modport sink (input valid, func, run_len, is_tracker, slot, tag, playing_mask,
                output ready);
endinterface

interface cga_rsp_if import cga_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                ok;
  logic [SLOT_W-1:0]   start_channel;
  logic [TAG_W-1:0]    new_tag;
  logic                stop_valid;
  logic                stop_tracker;
  logic                done_res;
  logic [MASK_W-1:0]   freed_mask;
  logic [MASK_W-1:0]   alloc_mask;

  modport source (output valid, ok, start_channel, new_tag, stop_valid, stop_tracker,
                  done_res, freed_mask, alloc_mask, input ready);
  modport sink (input valid, ok, start_channel, new_tag, stop_valid, stop_tracker,
                done_res, freed_mask, alloc_mask, output ready);
endinterface

[design/cga_ctrl.sv]
// Controller of the channel group allocator: sequences the channel walks.
// Depends on cga_pkg for the command and status structs.
module cga_ctrl import cga_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [FUNC_W-1:0] in_func_i,
  output logic              in_ready_o,
  input  sts_t              sts_i,
  output cmd_t              cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_STAMP,
    S_STOP,
    S_QUERY,
    S_CLEAR,
    S_SWEEP,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.op       = OP_NONE;
    cmd_o.out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          case (in_func_i)
            FUNC_ALLOC: state_d = sts_i.bad_count ? S_FINISH : S_SCAN;
            FUNC_STOP:  state_d = S_STOP;
            FUNC_QUERY: state_d = S_QUERY;
            FUNC_SWEEP: state_d = S_SWEEP;
            default:    state_d = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (sts_i.found) begin
          state_d = S_STAMP;
        end else if (sts_i.last) begin
          state_d = S_FINISH;
        end
      end
      S_STAMP: begin
        cmd_o.op = OP_STAMP;
        if (sts_i.stamp_last) begin
          state_d = S_FINISH;
        end
      end
      S_STOP: begin
        cmd_o.op = OP_STOP_CHK;
        state_d  = sts_i.trk_hit ? S_CLEAR : S_FINISH;
      end
      S_QUERY: begin
        cmd_o.op = OP_QUERY_CHK;
        state_d  = S_FINISH;
      end
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (!sts_i.run_go || sts_i.last) begin
          state_d = S_FINISH;
        end
      end
      S_SWEEP: begin
        cmd_o.op = OP_SWEEP;
        if (sts_i.last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

[design/cga_dpath.sv]
// Datapath of the channel group allocator: channel table, tag memory,
// walk index, result and output registers. Depends on cga_pkg.
module cga_dpath import cga_pkg::*; #(
  parameter int NUM_CHANNELS = 32,
  parameter int TAG_BITS     = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [FUNC_W-1:0]  in_func_i,
  input  logic [COUNT_W-1:0] in_count_i,
  input  logic               in_tracker_i,
  input  logic [SLOT_W-1:0]  in_slot_i,
  input  logic [TAG_W-1:0]   in_tag_i,
  input  logic [MASK_W-1:0]  in_playing_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_ok_o,
  output logic [SLOT_W-1:0]  out_start_o,
  output logic [TAG_W-1:0]   out_tag_o,
  output logic               out_stop_valid_o,
  output logic               out_stop_tracker_o,
  output logic               out_done_o,
  output logic [MASK_W-1:0]  out_freed_o,
  output logic [MASK_W-1:0]  out_alloc_o
);

  localparam int IDX_W = $clog2(NUM_CHANNELS);
  localparam int EXT_W = (NUM_CHANNELS > MASK_W) ? NUM_CHANNELS : MASK_W;
  localparam int TX_W  = (TAG_BITS > TAG_W) ? TAG_BITS : TAG_W;
  localparam int WIDE_W = COUNT_W + 1;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_CHANNELS - 1);
  localparam logic [WIDE_W-1:0] NUM_CH_W = WIDE_W'(NUM_CHANNELS);

  // Walk state.
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [IDX_W-1:0]        end_q, end_d;
  logic [COUNT_W-1:0]      run_q, run_d;
  logic [COUNT_W-1:0]      count_q, count_d;
  logic                    trk_q, trk_d;
  logic [TAG_BITS-1:0]     ref_tag_q, ref_tag_d;
  logic                    in_range_q, in_range_d;
  logic [MASK_W-1:0]       pm_q, pm_d;
  logic                    prev_occ_q, prev_occ_d;
  logic [TAG_BITS-1:0]     prev_tag_q, prev_tag_d;
  logic                    grp_free_q, grp_free_d;

  // Channel table.
  logic [NUM_CHANNELS-1:0] occ_q, occ_d;
  logic [NUM_CHANNELS-1:0] kind_q, kind_d;
  logic [TAG_BITS-1:0]     tagctr_q, tagctr_d;
  logic [TAG_BITS-1:0]     tag_mem_q [NUM_CHANNELS];
  logic [TAG_BITS-1:0]     rd_q;

  // Results of the item in progress.
  logic                    res_ok_q, res_ok_d;
  logic [IDX_W-1:0]        res_start_q, res_start_d;
  logic [TAG_BITS-1:0]     res_tag_q, res_tag_d;
  logic                    res_sv_q, res_sv_d;
  logic                    res_st_q, res_st_d;
  logic                    res_done_q, res_done_d;
  logic [NUM_CHANNELS-1:0] freed_q, freed_d;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  logic                    out_ok_q;
  logic [SLOT_W-1:0]       out_start_q;
  logic [TAG_W-1:0]        out_tag_q;
  logic                    out_sv_q;
  logic                    out_st_q;
  logic                    out_done_q;
  logic [MASK_W-1:0]       out_freed_q;
  logic [MASK_W-1:0]       out_alloc_q;

  logic [WIDE_W-1:0]       slot_w;
  logic                    slot_in_range;
  logic [TX_W-1:0]         tag_in_x;
  logic [EXT_W-1:0]        pm_ext;
  logic [EXT_W-1:0]        occ_ext;
  logic [EXT_W-1:0]        freed_ext;
  logic [TX_W-1:0]         tag_out_x;
  logic [WIDE_W-1:0]       start_x;
  logic [WIDE_W-1:0]       scan_start_w;
  logic [IDX_W-1:0]        idx_inc;
  logic [COUNT_W-1:0]      run_inc;
  logic [TAG_BITS-1:0]     tag_next;
  logic                    occ_i;
  logic                    kind_i;
  logic                    play_i;
  logic                    is_last;
  logic                    match;
  logic                    run_go;
  logic                    is_start;
  logic                    free_now;

  assign slot_w        = WIDE_W'(in_slot_i);
  assign slot_in_range = (slot_w < NUM_CH_W);
  assign tag_in_x      = TX_W'(in_tag_i);
  assign pm_ext        = EXT_W'(pm_q);
  assign occ_ext       = EXT_W'(occ_q);
  assign freed_ext     = EXT_W'(freed_q);
  assign tag_out_x     = TX_W'(res_tag_q);
  assign start_x       = WIDE_W'(res_start_q);

  assign occ_i    = occ_q[idx_q];
  assign kind_i   = kind_q[idx_q];
  assign play_i   = pm_ext[idx_q];
  assign is_last  = (idx_q == LAST_IDX);
  assign idx_inc  = is_last ? idx_q : idx_q + 1'b1;
  assign run_inc  = run_q + 1'b1;
  assign tag_next = tagctr_q + 1'b1;
  assign scan_start_w = WIDE_W'(idx_q) + WIDE_W'(1) - WIDE_W'(count_q);

  // The tag read is registered, so rd_q always holds the tag of channel idx_q.
  assign match  = in_range_q && occ_i && (rd_q == ref_tag_q);
  assign run_go = occ_i && (rd_q == ref_tag_q);

  // A group starts where the previous channel is empty or carries another tag.
  assign is_start = occ_i && ((idx_q == '0) || !prev_occ_q || (rd_q != prev_tag_q));
  assign free_now = is_start ? !play_i : grp_free_q;

  always_comb begin
    sts_o.bad_count  = (in_count_i == '0) || (WIDE_W'(in_count_i) > NUM_CH_W);
    sts_o.found      = !occ_i && (run_inc == count_q);
    sts_o.last       = is_last;
    sts_o.stamp_last = (idx_q == end_q);
    sts_o.trk_hit    = match && kind_i;
    sts_o.run_go     = run_go;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    idx_d       = idx_q;
    end_d       = end_q;
    run_d       = run_q;
    count_d     = count_q;
    trk_d       = trk_q;
    ref_tag_d   = ref_tag_q;
    in_range_d  = in_range_q;
    pm_d        = pm_q;
    prev_occ_d  = prev_occ_q;
    prev_tag_d  = prev_tag_q;
    grp_free_d  = grp_free_q;
    occ_d       = occ_q;
    kind_d      = kind_q;
    tagctr_d    = tagctr_q;
    res_ok_d    = res_ok_q;
    res_start_d = res_start_q;
    res_tag_d   = res_tag_q;
    res_sv_d    = res_sv_q;
    res_st_d    = res_st_q;
    res_done_d  = res_done_q;
    freed_d     = freed_q;
    case (cmd_i.op)
      OP_ACCEPT: begin
        count_d     = in_count_i;
        trk_d       = in_tracker_i;
        ref_tag_d   = tag_in_x[TAG_BITS-1:0];
        in_range_d  = slot_in_range;
        pm_d        = in_playing_i;
        run_d       = '0;
        res_ok_d    = 1'b0;
        res_start_d = '0;
        res_tag_d   = '0;
        res_sv_d    = 1'b0;
        res_st_d    = 1'b0;
        res_done_d  = 1'b0;
        freed_d     = '0;
        if (((in_func_i == FUNC_STOP) || (in_func_i == FUNC_QUERY)) && slot_in_range) begin
          idx_d = slot_w[IDX_W-1:0];
        end else begin
          idx_d = '0;
        end
      end
      OP_SCAN: begin
        run_d = occ_i ? '0 : run_inc;
        if (sts_o.found) begin
          idx_d       = scan_start_w[IDX_W-1:0];
          end_d       = idx_q;
          tagctr_d    = tag_next;
          res_ok_d    = 1'b1;
          res_start_d = scan_start_w[IDX_W-1:0];
          res_tag_d   = tag_next;
        end else begin
          idx_d = idx_inc;
        end
      end
      OP_STAMP: begin
        occ_d[idx_q]  = 1'b1;
        kind_d[idx_q] = trk_q;
        idx_d         = idx_inc;
      end
      OP_STOP_CHK: begin
        if (match) begin
          res_ok_d = 1'b1;
          res_sv_d = 1'b1;
          res_st_d = kind_i;
        end
      end
      OP_QUERY_CHK: begin
        res_done_d = !(match && play_i);
      end
      OP_CLEAR: begin
        if (run_go) begin
          occ_d[idx_q]   = 1'b0;
          kind_d[idx_q]  = 1'b0;
          freed_d[idx_q] = 1'b1;
          idx_d          = idx_inc;
        end
      end
      OP_SWEEP: begin
        prev_occ_d = occ_i;
        prev_tag_d = rd_q;
        grp_free_d = free_now;
        if (occ_i && free_now) begin
          occ_d[idx_q]   = 1'b0;
          kind_d[idx_q]  = 1'b0;
          freed_d[idx_q] = 1'b1;
        end
        idx_d = idx_inc;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      kind_q      <= '0;
      tagctr_q    <= TAG_BITS'(1);
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      kind_q      <= kind_d;
      tagctr_q    <= tagctr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    end_q       <= end_d;
    run_q       <= run_d;
    count_q     <= count_d;
    trk_q       <= trk_d;
    ref_tag_q   <= ref_tag_d;
    in_range_q  <= in_range_d;
    pm_q        <= pm_d;
    prev_occ_q  <= prev_occ_d;
    prev_tag_q  <= prev_tag_d;
    grp_free_q  <= grp_free_d;
    res_ok_q    <= res_ok_d;
    res_start_q <= res_start_d;
    res_tag_q   <= res_tag_d;
    res_sv_q    <= res_sv_d;
    res_st_q    <= res_st_d;
    res_done_q  <= res_done_d;
    freed_q     <= freed_d;
    if (cmd_i.out_load) begin
      out_ok_q    <= res_ok_q;
      out_start_q <= start_x[SLOT_W-1:0];
      out_tag_q   <= tag_out_x[TAG_W-1:0];
      out_sv_q    <= res_sv_q;
      out_st_q    <= res_st_q;
      out_done_q  <= res_done_q;
      out_freed_q <= freed_ext[MASK_W-1:0];
      out_alloc_q <= occ_ext[MASK_W-1:0];
    end
  end

  // Tag memory: one write port for stamping, one registered read port that
  // follows the next walk index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_STAMP) begin
      tag_mem_q[idx_q] <= tagctr_q;
    end
    rd_q <= tag_mem_q[idx_d];
  end

  assign out_valid_o        = out_valid_q;
  assign out_ok_o           = out_ok_q;
  assign out_start_o        = out_start_q;
  assign out_tag_o          = out_tag_q;
  assign out_stop_valid_o   = out_sv_q;
  assign out_stop_tracker_o = out_st_q;
  assign out_done_o         = out_done_q;
  assign out_freed_o        = out_freed_q;
  assign out_alloc_o        = out_alloc_q;

endmodule

[design/channel_group_allocator_top.sv]
// Top level of the channel group allocator: controller plus datapath.
// Depends on cga_pkg, cga_if, cga_ctrl and cga_dpath.
//
// The allocator keeps a table of NUM_CHANNELS mixer channels, each with an
// occupied bit, a TAG_BITS generation tag and a sample-or-tracker kind. It
// takes one request word at a time on req_i and answers each with exactly one
// response word on rsp_o. An allocate walks the channels one per cycle looking
// for the first free run of the requested length, then stamps the run one
// channel per cycle with the next tag; an allocate that finds no room walks the
// whole table, and a bad count is answered without a walk. A sweep walks every
// channel once. A query and a stop each check only the addressed channel; when
// a stop frees a tracker group it then clears the run one channel at a time,
// with one more check that finds the end of the run unless the run reaches the
// top channel. The walk index and the single read port of the tag memory mean
// that each cycle looks at one channel. Each answer is further held while the
// previous response still waits in the output register. A new request is taken
// only when the previous one has finished its walk; the finished response sits
// in an output register, so the next request can be accepted while it waits
// for rsp_o.ready.
// There is no clearing pass after reset: unused tags are never compared,
// because only occupied channels, whose tags were written, take part.
module channel_group_allocator_top import cga_pkg::*; #(
  parameter int NUM_CHANNELS = 32,
  parameter int TAG_BITS     = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cga_req_if.sink    req_i,
  cga_rsp_if.source  rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences the walk and decides when a word is accepted.
  cga_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_func_i  (req_i.func),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the channel table and the response register.
  cga_dpath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .TAG_BITS     (TAG_BITS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .in_func_i          (req_i.func),
    .in_count_i         (req_i.run_len),
    .in_tracker_i       (req_i.is_tracker),
    .in_slot_i          (req_i.slot),
    .in_tag_i           (req_i.tag),
    .in_playing_i       (req_i.playing_mask),
    .out_valid_o        (rsp_o.valid),
    .out_ready_i        (rsp_o.ready),
    .out_ok_o           (rsp_o.ok),
    .out_start_o        (rsp_o.start_channel),
    .out_tag_o          (rsp_o.new_tag),
    .out_stop_valid_o   (rsp_o.stop_valid),
    .out_stop_tracker_o (rsp_o.stop_tracker),
    .out_done_o         (rsp_o.done_res),
    .out_freed_o        (rsp_o.freed_mask),
    .out_alloc_o        (rsp_o.alloc_mask)
  );

endmodule

[design/cga_checker.sv]
// Port-level checks of the channel group allocator and their bind.
// Depends on cga_pkg and on channel_group_allocator_top.
module cga_checker import cga_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic              rsp_ok_i,
  input logic [SLOT_W-1:0] rsp_start_i,
  input logic [TAG_W-1:0]  rsp_tag_i,
  input logic              rsp_stop_valid_i,
  input logic              rsp_stop_tracker_i,
  input logic              rsp_done_i,
  input logic [MASK_W-1:0] rsp_freed_i,
  input logic [MASK_W-1:0] rsp_alloc_i
);

  // A response word waits until it is taken.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response word dropped before it was taken");

  // Without success there is no start channel and no tag.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ok_i |-> (rsp_start_i == '0) && (rsp_tag_i == '0))
    else $error("start channel or tag reported without success");

  // A channel freed by this word is not occupied after it.
  a_freed_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> ((rsp_freed_i & rsp_alloc_i) == '0))
    else $error("freed channel still shown as occupied");

  // A tracker stop is always an issued, matched stop.
  a_trk_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_stop_tracker_i |-> rsp_stop_valid_i && rsp_ok_i)
    else $error("tracker stop without a matched stop");

  // A query result carries nothing from other functions.
  a_done_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_done_i |-> !rsp_ok_i && !rsp_stop_valid_i && (rsp_freed_i == '0))
    else $error("query result mixed with other results");

endmodule

bind channel_group_allocator_top cga_checker u_cga_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_ok_i           (rsp_o.ok),
  .rsp_start_i        (rsp_o.start_channel),
  .rsp_tag_i          (rsp_o.new_tag),
  .rsp_stop_valid_i   (rsp_o.stop_valid),
  .rsp_stop_tracker_i (rsp_o.stop_tracker),
  .rsp_done_i         (rsp_o.done_res),
  .rsp_freed_i        (rsp_o.freed_mask),
  .rsp_alloc_i        (rsp_o.alloc_mask)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for channel_group_allocator_top.
// Depends on cga_pkg, cga_req_if and cga_rsp_if, and on the design files.
// Directed checks first, then long runs of random requests with random idling.
module tb_top import cga_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH            = 32;
  localparam int ACCEPT_TIMEOUT = 2000;       // cycles with no word moving on either side
  localparam int TAIL_CYCLES    = 2 * NCH + 8; // settle time after the last response
  localparam int HANDLE_DEPTH   = 48;

  // One request word and one response word, at the widths of the ports.
  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [COUNT_W-1:0] run_len;
    logic               is_tracker;
    logic [SLOT_W-1:0]  slot;
    logic [TAG_W-1:0]   tag;
    logic [MASK_W-1:0]  playing_mask;
  } req_t;

  typedef struct {
    logic               ok;
    logic [SLOT_W-1:0]  start_channel;
    logic [TAG_W-1:0]   new_tag;
    logic               stop_valid;
    logic               stop_tracker;
    logic               done_res;
    logic [MASK_W-1:0]  freed_mask;
    logic [MASK_W-1:0]  alloc_mask;
  } rsp_t;

  // A handle as software would keep it: start channel plus generation tag.
  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
  } handle_t;

  logic clk;
  logic rst_n;

  cga_req_if req_if ();
  cga_rsp_if rsp_if ();

  channel_group_allocator_top #(
    .NUM_CHANNELS(NCH),
    .TAG_BITS    (TAG_W)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // 4 ns clock: 2 ns high, 2 ns low.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the channel table, kept in step with every accepted word.
  logic             chan_busy [NCH];
  logic [TAG_W-1:0] chan_tag  [NCH];
  logic             chan_trk  [NCH];
  logic [TAG_W-1:0] tag_seq;

  rsp_t    due_rsps[$];      // responses owed by the block, oldest first
  handle_t live_handles[$];  // handles handed out by allocates, some gone stale
  int      mismatches = 0;
  bit      calm = 1'b0;      // while set, neither side idles

  // One past the last channel of the group that starts at s.
  function automatic int group_end(int s);
    int j;
    j = s;
    while (j < NCH && chan_busy[j] && chan_tag[j] == chan_tag[s]) j++;
    return j;
  endfunction

  function automatic logic [MASK_W-1:0] clear_run(int s, int e);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int k = s; k < e; k++) begin
      chan_busy[k] = 1'b0;
      chan_tag[k]  = '0;
      chan_trk[k]  = 1'b0;
      m[k]         = 1'b1;
    end
    return m;
  endfunction

  // An empty channel never matches, even when the handle tag equals its
  // cleared tag of zero.
  function automatic bit handle_hit(logic [SLOT_W-1:0] s, logic [TAG_W-1:0] t);
    return chan_busy[s] && chan_tag[s] == t;
  endfunction

  // Applies one request to the shadow table and returns the response it earns.
  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int   i;
    int   e;
    bit   fits;
    bit   placed;
    o = '{default: '0};
    placed = 1'b0;
    case (r.func)
      FUNC_ALLOC: begin
        // First fit: the lowest start whose whole run is free. A count of
        // zero or above the table size fails without touching the counter.
        if (r.run_len >= 1 && r.run_len <= NCH) begin
          for (i = 0; i + r.run_len <= NCH && !placed; i++) begin
            fits = 1'b1;
            for (int k = 0; k < r.run_len; k++)
              if (chan_busy[i + k]) fits = 1'b0;
            if (fits) begin
              tag_seq = tag_seq + 1'b1;
              for (int k = 0; k < r.run_len; k++) begin
                chan_busy[i + k] = 1'b1;
                chan_tag[i + k]  = tag_seq;
                chan_trk[i + k]  = r.is_tracker;
              end
              o.ok            = 1'b1;
              o.start_channel = SLOT_W'(i);
              o.new_tag       = tag_seq;
              placed          = 1'b1;
            end
          end
        end
      end
      FUNC_STOP: begin
        // A sample only gets a stop command; a tracker group is freed now.
        if (handle_hit(r.slot, r.tag)) begin
          o.ok         = 1'b1;
          o.stop_valid = 1'b1;
          if (chan_trk[r.slot]) begin
            o.stop_tracker = 1'b1;
            o.freed_mask   = clear_run(int'(r.slot), group_end(int'(r.slot)));
          end
        end
      end
      FUNC_QUERY: begin
        o.done_res = !(handle_hit(r.slot, r.tag) && r.playing_mask[r.slot]);
      end
      default: begin
        // Sweep: a group goes when its first channel has stopped playing.
        i = 0;
        while (i < NCH) begin
          if (!chan_busy[i]) begin
            i++;
          end else begin
            e = group_end(i);
            if (!r.playing_mask[i]) o.freed_mask |= clear_run(i, e);
            i = e;
          end
        end
      end
    endcase
    for (int k = 0; k < NCH; k++) o.alloc_mask[k] = chan_busy[k];
    return o;
  endfunction

  function automatic req_t make_req(logic [FUNC_W-1:0] func, int count, bit trk,
                                    int slot, int tag, logic [MASK_W-1:0] pm);
    req_t r;
    r.func         = func;
    r.run_len      = COUNT_W'(count);
    r.is_tracker   = trk;
    r.slot         = SLOT_W'(slot);
    r.tag          = TAG_W'(tag);
    r.playing_mask = pm;
    return r;
  endfunction

  // Mostly well-formed traffic: allocates of short runs, stops and queries on
  // handles that were handed out, and sweeps. A few words are pure noise.
  function automatic req_t random_request();
    req_t    r;
    int      pick;
    int      size_pick;
    handle_t h;
    r.func         = FUNC_W'($urandom_range(3));
    r.run_len      = COUNT_W'($urandom_range(63));
    r.is_tracker   = 1'($urandom_range(1));
    r.slot         = SLOT_W'($urandom_range(NCH - 1));
    r.tag          = TAG_W'($urandom_range(65535));
    r.playing_mask = $urandom();
    pick = $urandom_range(99);
    if (pick < 5) begin
      // Noise: every field random.
    end else if (pick < 40) begin
      r.func = FUNC_ALLOC;
      size_pick = $urandom_range(99);
      if (size_pick < 85)      r.run_len = COUNT_W'($urandom_range(6, 1));
      else if (size_pick < 95) r.run_len = COUNT_W'($urandom_range(NCH, 7));
      else                     r.run_len = COUNT_W'($urandom_range(63));
    end else if (pick < 85) begin
      r.func = (pick < 60) ? FUNC_STOP : FUNC_QUERY;
      if (live_handles.size() > 0 && $urandom_range(99) < 85) begin
        h = live_handles[$urandom_range(live_handles.size() - 1)];
        r.slot = h.slot;
        if ($urandom_range(99) < 85) r.tag = h.tag;
        if ($urandom_range(99) < 60) r.playing_mask[h.slot] = 1'b1;
      end
    end else begin
      r.func = FUNC_SWEEP;
      // Half the sweeps see most channels still playing, so fewer groups go.
      if ($urandom_range(1)) r.playing_mask = $urandom() | $urandom();
    end
    return r;
  endfunction

  // Sends one word: random idle cycles first unless calm is set, then holds valid until ready.
  // Valid is left high so that a following word goes out without a gap.
  task automatic send_request(input req_t r, output rsp_t predicted);
    handle_t h;
    @(negedge clk);
    if (!calm) begin
      while ($urandom_range(99) < 33) begin
        req_if.valid = 1'b0;
        @(negedge clk);
      end
    end
    req_if.valid        = 1'b1;
    req_if.func         = r.func;
    req_if.run_len      = r.run_len;
    req_if.is_tracker   = r.is_tracker;
    req_if.slot         = r.slot;
    req_if.tag          = r.tag;
    req_if.playing_mask = r.playing_mask;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    predicted = apply_request(r);
    due_rsps.push_back(predicted);
    if (r.func == FUNC_ALLOC && predicted.ok) begin
      h.slot = predicted.start_channel;
      h.tag  = predicted.new_tag;
      live_handles.push_back(h);
      if (live_handles.size() > HANDLE_DEPTH) void'(live_handles.pop_front());
    end
  endtask

  // Stops sending and waits until every owed response has come back.
  task automatic wait_for_responses();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (due_rsps.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Count limits, a full table, queries and stops on a sample group, sweeps.
  task automatic test_alloc_limits();
    rsp_t    got;
    handle_t full;
    send_request(make_req(FUNC_ALLOC, 0, 1'b0, 0, 0, '0), got);   // zero count
    send_request(make_req(FUNC_ALLOC, 33, 1'b0, 0, 0, '0), got);  // one above the table
    send_request(make_req(FUNC_ALLOC, 63, 1'b1, 0, 0, '0), got);  // largest count field
    send_request(make_req(FUNC_ALLOC, NCH, 1'b0, 0, 0, '0), got); // whole table
    full.slot = got.start_channel;
    full.tag  = got.new_tag;
    send_request(make_req(FUNC_ALLOC, 1, 1'b0, 0, 0, '0), got);   // no room left
    send_request(make_req(FUNC_QUERY, 0, 1'b0, int'(full.slot), int'(full.tag), '1), got);
    send_request(make_req(FUNC_QUERY, 0, 1'b0, int'(full.slot), int'(full.tag),
                          32'hFFFF_FFFE), got);
    send_request(make_req(FUNC_QUERY, 0, 1'b0, int'(full.slot),
                          int'(full.tag ^ 16'h8001), '1), got);
    send_request(make_req(FUNC_STOP, 0, 1'b0, int'(full.slot),
                          int'(full.tag ^ 16'h0001), '1), got);
    send_request(make_req(FUNC_STOP, 0, 1'b0, int'(full.slot), int'(full.tag), '1), got);
    send_request(make_req(FUNC_SWEEP, 0, 1'b0, 0, 0, '1), got);   // everything plays
    send_request(make_req(FUNC_SWEEP, 0, 1'b0, 0, 0, '0), got);   // everything stopped
  endtask

  // Tracker groups freed by stop, first fit around holes, the top channel.
  task automatic test_tracker_groups();
    rsp_t    got;
    handle_t trk_low;
    handle_t trk_high;
    send_request(make_req(FUNC_ALLOC, 4, 1'b1, 0, 0, '0), got);
    trk_low.slot = got.start_channel;
    trk_low.tag  = got.new_tag;
    send_request(make_req(FUNC_ALLOC, 3, 1'b0, 0, 0, '0), got);
    send_request(make_req(FUNC_ALLOC, NCH - 7, 1'b1, 0, 0, '0), got); // ends at the top
    trk_high.slot = got.start_channel;
    trk_high.tag  = got.new_tag;
    send_request(make_req(FUNC_STOP, 0, 1'b0, int'(trk_low.slot), int'(trk_low.tag), '1),
                 got);
    send_request(make_req(FUNC_STOP, 0, 1'b0, int'(trk_low.slot), int'(trk_low.tag), '1),
                 got);
    send_request(make_req(FUNC_QUERY, 0, 1'b0, 0, 0, '1), got);      // empty, tag zero
    send_request(make_req(FUNC_ALLOC, 2, 1'b0, 0, 0, '0), got);      // into the hole
    send_request(make_req(FUNC_ALLOC, 3, 1'b0, 0, 0, '0), got);      // hole too short
    send_request(make_req(FUNC_QUERY, 0, 1'b0, NCH - 1, 'hFFFF, '1), got);
    send_request(make_req(FUNC_STOP, 0, 1'b1, int'(trk_high.slot), int'(trk_high.tag), '0),
                 got);
    send_request(make_req(FUNC_SWEEP, 0, 1'b0, 0, 0, 32'h0000_0010), got);
    send_request(make_req(FUNC_SWEEP, 0, 1'b0, 0, 0, '0), got);
  endtask

  task automatic test_random_mix(input int n);
    rsp_t got;
    repeat (n) send_request(random_request(), got);
  endtask

  // The sender holds off until the block has answered everything, then resumes.
  task automatic test_drain_pause(input int n);
    wait_for_responses();
    test_random_mix(n);
  endtask

  // A stretch in which neither side idles, so words follow each other closely.
  task automatic test_back_to_back(input int n);
    calm = 1'b1;
    test_random_mix(n);
    calm = 1'b0;
  endtask

  // The response side is ready at random, about two times in three, except while
  // calm is set. Ready changes only on the falling edge.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready = calm || ($urandom_range(99) >= 33);
    end
  end

  // Every response taken is matched, field by field, with the oldest owed one.
  initial begin : rsp_checker
    rsp_t want;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (due_rsps.size() == 0) begin
          $error("response word with none expected");
          mismatches++;
        end else begin
          want = due_rsps.pop_front();
          check_field("ok",            32'(want.ok),            32'(rsp_if.ok));
          check_field("start_channel", 32'(want.start_channel), 32'(rsp_if.start_channel));
          check_field("new_tag",       32'(want.new_tag),       32'(rsp_if.new_tag));
          check_field("stop_valid",    32'(want.stop_valid),    32'(rsp_if.stop_valid));
          check_field("stop_tracker",  32'(want.stop_tracker),  32'(rsp_if.stop_tracker));
          check_field("done_res",      32'(want.done_res),      32'(rsp_if.done_res));
          check_field("freed_mask",    want.freed_mask,         rsp_if.freed_mask);
          check_field("alloc_mask",    want.alloc_mask,         rsp_if.alloc_mask);
        end
      end
    end
  end

  // Ends the run when no word has moved on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < ACCEPT_TIMEOUT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("** channel_group_allocator_top: FAILED **");
    $finish;
  end

  // Stimulus sequence. The shadow table starts in the reset state: all
  // channels free and the tag counter at one, so the first allocate gets two.
  initial begin
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.func         = FUNC_ALLOC;
    req_if.run_len      = '0;
    req_if.is_tracker   = 1'b0;
    req_if.slot         = '0;
    req_if.tag          = '0;
    req_if.playing_mask = '0;
    for (int k = 0; k < NCH; k++) begin
      chan_busy[k] = 1'b0;
      chan_tag[k]  = '0;
      chan_trk[k]  = 1'b0;
    end
    tag_seq = TAG_W'(1);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_alloc_limits();
    test_tracker_groups();
    test_random_mix(330);
    test_drain_pause(120);
    test_back_to_back(200);
    test_random_mix(175);

    wait_for_responses();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_rsps.size() == 0) begin
      $display("** channel_group_allocator_top: PASSED **");
    end else begin
      $display("** channel_group_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule
